// ===== hdl/qpd_pkg.sv =====
// Shared types and constants for the QMTP packet deframer.
// Depends on nothing; every file but the two channel interfaces imports it.
`default_nettype none
package qpd_pkg;

	localparam int unsigned LEN_W = 31;
	localparam logic [LEN_W-1:0] LEN_CEILING = 31'd200000000;

	localparam logic [15:0] ADDR_LIMIT_RESET = 16'd1000;
	localparam logic [9:0]  RELAY_SUFFIX_RESET = 10'd0;

	localparam logic CFG_IDX_ADDR_LIMIT = 1'b0;
	localparam logic CFG_IDX_RELAY_SUFFIX = 1'b1;

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [2:0] KIND_BODY      = 3'd0;
	localparam logic [2:0] KIND_SENDER    = 3'd1;
	localparam logic [2:0] KIND_RECIPIENT = 3'd2;
	localparam logic [2:0] KIND_BODY_END  = 3'd3;
	localparam logic [2:0] KIND_SND_END   = 3'd4;
	localparam logic [2:0] KIND_RCP_END   = 3'd5;
	localparam logic [2:0] KIND_PKT_END   = 3'd6;
	localparam logic [2:0] KIND_ERROR     = 3'd7;

	localparam logic [1:0] VERD_OK   = 2'd0;
	localparam logic [1:0] VERD_LONG = 2'd1;
	localparam logic [1:0] VERD_NUL  = 2'd2;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_PROTO = 2'd1;
	localparam logic [1:0] ERR_LEN   = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] item_kind;
		logic [1:0] verdict;
		logic [1:0] error_code;
		logic       run_last;
	} qpd_result_t;

	typedef struct packed {
		logic [1:0]  count;
		qpd_result_t r0;
		qpd_result_t r1;
	} qpd_push_t;

	typedef struct packed {
		logic [15:0] address_limit;
		logic [9:0]  relay_suffix_len;
	} qpd_cfg_t;

endpackage
`default_nettype wire

// ===== hdl/qpd_in_if.sv =====
// Input byte channel: valid, ready and one received byte.
// Depends on nothing.
`default_nettype none
interface qpd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/qpd_out_if.sv =====
// Result channel: valid, ready and the fields of one deframer result.
// Depends on nothing.
`default_nettype none
interface qpd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [2:0] item_kind;
	logic [1:0] verdict;
	logic [1:0] error_code;
	logic       run_last;

	modport source (output valid, output data_byte, output item_kind, output verdict,
		output error_code, output run_last, input ready);
	modport sink (input valid, input data_byte, input item_kind, input verdict,
		input error_code, input run_last, output ready);
endinterface
`default_nettype wire

// ===== hdl/qpd_step.sv =====
// Parse state and per-byte next-state logic; yields up to two results per byte.
// Depends on qpd_pkg.
`default_nettype none
module qpd_step
	import qpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       fire,
	input  wire logic [7:0] in_byte,
	input  wire qpd_cfg_t   cfg,
	output qpd_push_t       push
);

	typedef enum logic [3:0] {
		PH_MSG_LEN, PH_MSG_MODE, PH_BODY, PH_MSG_COMMA,
		PH_SND_LEN, PH_SND_DATA, PH_SND_COMMA,
		PH_LIST_LEN, PH_RCP_LEN, PH_RCP_DATA, PH_RCP_COMMA, PH_LIST_COMMA,
		PH_FAILED
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [LEN_W-1:0] field_q, field_d;
	logic [LEN_W-1:0] list_q, list_d;
	logic             crlf_q, crlf_d;
	logic             cr_q, cr_d;
	logic             dropped_q, dropped_d;
	logic [1:0]       verdict_q, verdict_d;

	logic [LEN_W-1:0] field_dec, list_dec, list_after, field_digit;
	logic [LEN_W:0]   rcp_sum;
	logic             is_digit;
	logic [1:0]       digit_err, fail_code, n;
	qpd_result_t      r0, r1;

	function automatic qpd_result_t mk(input logic [7:0] d, input logic [2:0] k,
		input logic [1:0] v, input logic [1:0] c);
		qpd_result_t r;
		r.data_byte = d;
		r.item_kind = k;
		r.verdict = v;
		r.error_code = c;
		r.run_last = 1'b0;
		return r;
	endfunction

	assign field_dec = field_q - LEN_W'(1);
	assign list_dec = list_q - LEN_W'(1);
	assign list_after = list_dec - field_q - LEN_W'(1);
	assign rcp_sum = {1'b0, field_q} + (LEN_W+1)'(cfg.relay_suffix_len);
	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign field_digit = {field_q[LEN_W-4:0], 3'b000} + {field_q[LEN_W-2:0], 1'b0}
		+ LEN_W'(in_byte[3:0]);

	always_comb begin
		if (field_q > LEN_CEILING) digit_err = ERR_LEN;
		else if (!is_digit) digit_err = ERR_PROTO;
		else digit_err = ERR_NONE;
	end

	always_comb begin
		phase_d = phase_q;
		field_d = field_q;
		list_d = list_q;
		crlf_d = crlf_q;
		cr_d = cr_q;
		dropped_d = dropped_q;
		verdict_d = verdict_q;
		fail_code = ERR_NONE;
		n = 2'd0;
		r0 = '0;
		r1 = '0;
		unique case (phase_q)
			PH_MSG_LEN, PH_SND_LEN, PH_LIST_LEN: begin
				if (in_byte == CH_COLON) begin
					if (phase_q == PH_MSG_LEN) begin
						if (field_q == '0) fail_code = ERR_PROTO;
						else phase_d = PH_MSG_MODE;
					end else if (phase_q == PH_SND_LEN) begin
						dropped_d = field_q >= LEN_W'(cfg.address_limit);
						verdict_d = (field_q >= LEN_W'(cfg.address_limit)) ? VERD_LONG : VERD_OK;
						phase_d = (field_q != '0) ? PH_SND_DATA : PH_SND_COMMA;
					end else begin
						list_d = field_q;
						field_d = '0;
						phase_d = (field_q != '0) ? PH_RCP_LEN : PH_LIST_COMMA;
					end
				end else if (digit_err != ERR_NONE) begin
					fail_code = digit_err;
				end else begin
					field_d = field_digit;
				end
			end
			PH_MSG_MODE: begin
				if (in_byte == CH_LF || in_byte == CH_CR) begin
					crlf_d = (in_byte == CH_CR);
					cr_d = 1'b0;
					field_d = field_dec;
					phase_d = (field_dec != '0) ? PH_BODY : PH_MSG_COMMA;
				end else begin
					fail_code = ERR_PROTO;
				end
			end
			PH_BODY: begin
				field_d = field_dec;
				if (!crlf_q) begin
					n = 2'd1;
					r0 = mk(in_byte, KIND_BODY, VERD_OK, ERR_NONE);
				end else if (cr_q) begin
					if (in_byte == CH_LF) begin
						n = 2'd1;
						r0 = mk(CH_LF, KIND_BODY, VERD_OK, ERR_NONE);
						cr_d = 1'b0;
					end else if (in_byte == CH_CR && field_dec != '0) begin
						n = 2'd1;
						r0 = mk(CH_CR, KIND_BODY, VERD_OK, ERR_NONE);
					end else begin
						n = 2'd2;
						r0 = mk(CH_CR, KIND_BODY, VERD_OK, ERR_NONE);
						r1 = mk(in_byte, KIND_BODY, VERD_OK, ERR_NONE);
						cr_d = 1'b0;
					end
				end else if (in_byte == CH_CR && field_dec != '0) begin
					cr_d = 1'b1;
				end else begin
					n = 2'd1;
					r0 = mk(in_byte, KIND_BODY, VERD_OK, ERR_NONE);
				end
				if (field_dec == '0) phase_d = PH_MSG_COMMA;
			end
			PH_SND_DATA, PH_RCP_DATA: begin
				if (!dropped_q) begin
					if (in_byte == CH_NUL) verdict_d = VERD_NUL;
					n = 2'd1;
					r0 = mk(in_byte, (phase_q == PH_SND_DATA) ? KIND_SENDER : KIND_RECIPIENT,
						VERD_OK, ERR_NONE);
				end
				field_d = field_dec;
				if (field_dec == '0)
					phase_d = (phase_q == PH_SND_DATA) ? PH_SND_COMMA : PH_RCP_COMMA;
			end
			PH_RCP_LEN: begin
				if (list_q == '0) begin
					fail_code = ERR_PROTO;
				end else begin
					list_d = list_dec;
					if (in_byte == CH_COLON) begin
						if (field_q >= list_dec) begin
							fail_code = ERR_PROTO;
						end else begin
							list_d = list_after;
							dropped_d = rcp_sum >= (LEN_W+1)'(cfg.address_limit);
							verdict_d = (rcp_sum >= (LEN_W+1)'(cfg.address_limit)) ?
								VERD_LONG : VERD_OK;
							phase_d = (field_q != '0) ? PH_RCP_DATA : PH_RCP_COMMA;
						end
					end else if (digit_err != ERR_NONE) begin
						fail_code = digit_err;
					end else begin
						field_d = field_digit;
					end
				end
			end
			PH_MSG_COMMA, PH_SND_COMMA, PH_RCP_COMMA, PH_LIST_COMMA: begin
				if (in_byte != CH_COMMA) begin
					fail_code = ERR_PROTO;
				end else begin
					field_d = '0;
					n = 2'd1;
					if (phase_q == PH_MSG_COMMA) begin
						r0 = mk(8'h00, KIND_BODY_END, VERD_OK, ERR_NONE);
						phase_d = PH_SND_LEN;
					end else if (phase_q == PH_SND_COMMA) begin
						r0 = mk(8'h00, KIND_SND_END, verdict_q, ERR_NONE);
						phase_d = PH_LIST_LEN;
					end else if (phase_q == PH_RCP_COMMA) begin
						r0 = mk(8'h00, KIND_RCP_END, verdict_q, ERR_NONE);
						phase_d = (list_q != '0) ? PH_RCP_LEN : PH_LIST_COMMA;
					end else begin
						r0 = mk(8'h00, KIND_PKT_END, VERD_OK, ERR_NONE);
						phase_d = PH_MSG_LEN;
						list_d = '0;
						crlf_d = 1'b0;
						cr_d = 1'b0;
					end
					dropped_d = 1'b0;
					verdict_d = VERD_OK;
				end
			end
			default: begin
			end
		endcase
		if (fail_code != ERR_NONE) begin
			phase_d = PH_FAILED;
			n = 2'd1;
			r0 = mk(8'h00, KIND_ERROR, VERD_OK, fail_code);
		end
		if (n == 2'd2) r1.run_last = 1'b1;
		else r0.run_last = 1'b1;
	end

	always_comb begin
		push.count = fire ? n : 2'd0;
		push.r0 = r0;
		push.r1 = r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MSG_LEN;
			field_q <= '0;
			list_q <= '0;
			crlf_q <= 1'b0;
			cr_q <= 1'b0;
			dropped_q <= 1'b0;
			verdict_q <= VERD_OK;
		end else if (fire) begin
			phase_q <= phase_d;
			field_q <= field_d;
			list_q <= list_d;
			crlf_q <= crlf_d;
			cr_q <= cr_d;
			dropped_q <= dropped_d;
			verdict_q <= verdict_d;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/qpd_resq.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while out_ch is ready.
// Depends on qpd_pkg and qpd_out_if.
`default_nettype none
module qpd_resq
	import qpd_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire qpd_push_t  push,
	output logic            space_ok,
	qpd_out_if.source       out_ch
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	qpd_result_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q, wr_nx, wr_nx2, rd_nx;
	logic [CW-1:0] count_q;
	logic          pop;
	qpd_result_t   head;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign wr_nx = wrap_inc(wr_q);
	assign wr_nx2 = wrap_inc(wr_nx);
	assign rd_nx = wrap_inc(rd_q);
	assign pop = out_ch.valid && out_ch.ready;
	assign space_ok = count_q <= CW'(DEPTH - 2);
	assign head = mem_q[rd_q];

	assign out_ch.valid = count_q != '0;
	assign out_ch.data_byte = head.data_byte;
	assign out_ch.item_kind = head.item_kind;
	assign out_ch.verdict = head.verdict;
	assign out_ch.error_code = head.error_code;
	assign out_ch.run_last = head.run_last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.count == 2'd2) mem_q[wr_nx] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push.count == 2'd1) wr_q <= wr_nx;
			else if (push.count == 2'd2) wr_q <= wr_nx2;
			if (pop) rd_q <= rd_nx;
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/qmtp_packet_deframer_unit.sv =====
// QMTP packet deframer top level: config registers, parser, result queue.
// Results are registered in the result queue as their bytes are accepted.
// Throughput: one byte per cycle while the queue has room; the queue drains one
// result per cycle when out_ch is ready, so bytes that yield two results (lone CR) stall input once the queue fills.
// Reset clears parse state and queue, and loads register defaults.
// Depends on qpd_pkg, qpd_in_if, qpd_out_if, qpd_step, qpd_resq.
`default_nettype none
module qmtp_packet_deframer_unit
	import qpd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	qpd_in_if.sink           in_ch,
	qpd_out_if.source        out_ch,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	qpd_cfg_t  cfg_q;
	qpd_push_t push;
	logic      space_ok;
	logic      fire;

	assign in_ch.ready = space_ok;
	assign fire = in_ch.valid && space_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.address_limit <= ADDR_LIMIT_RESET;
			cfg_q.relay_suffix_len <= RELAY_SUFFIX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index[0])
				CFG_IDX_ADDR_LIMIT: cfg_q.address_limit <= cfg_data;
				CFG_IDX_RELAY_SUFFIX: cfg_q.relay_suffix_len <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	qpd_step u_step (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.in_byte(in_ch.in_byte),
		.cfg(cfg_q),
		.push(push)
	);

	qpd_resq #(.DEPTH(QUEUE_DEPTH)) u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.space_ok(space_ok),
		.out_ch(out_ch)
	);

endmodule
`default_nettype wire

// ===== hdl/qpd_checker.sv =====
// Port-level checks on the deframer's results, bound to the top level.
// Depends on qpd_pkg and qmtp_packet_deframer_unit.
`default_nettype none
module qpd_checker
	import qpd_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] data_byte,
	input wire logic [2:0] item_kind,
	input wire logic [1:0] verdict,
	input wire logic [1:0] error_code,
	input wire logic       run_last
);

	logic out_fire;
	assign out_fire = out_valid && out_ready;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && item_kind >= KIND_BODY_END |-> data_byte == 8'h00)
		else $error("marker item carries data");

	a_verdict_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && verdict != VERD_OK |-> item_kind == KIND_SND_END || item_kind == KIND_RCP_END)
		else $error("verdict outside address end item");

	a_error_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> (item_kind == KIND_ERROR) == (error_code != ERR_NONE))
		else $error("error code and kind disagree");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && item_kind == KIND_ERROR |-> run_last)
		else $error("error item not last of its byte");

endmodule

bind qmtp_packet_deframer_unit qpd_checker u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.data_byte(out_ch.data_byte),
	.item_kind(out_ch.item_kind),
	.verdict(out_ch.verdict),
	.error_code(out_ch.error_code),
	.run_last(out_ch.run_last)
);
`default_nettype wire

// ===== tb/sv/tb_qmtp_packet_deframer_unit.sv =====
// Testbench for qmtp_packet_deframer_unit: framed byte streams go in, and every
// result is checked in order against an independent deframer model or a directed row.
// Depends on qpd_pkg, qpd_in_if, qpd_out_if and the deframer RTL.
module tb_qmtp_packet_deframer_unit;
	import qpd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned RANDOM_BYTES = 1250;
	localparam int unsigned PHASES = 8;
	localparam logic [15:0] DIR_LIMIT = 16'd2;
	localparam logic [9:0] DIR_SUFFIX = 10'd1;

	typedef enum logic [3:0] {
		ST_MSG_LEN, ST_MSG_MODE, ST_BODY, ST_MSG_COMMA,
		ST_SND_LEN, ST_SND_DATA, ST_SND_COMMA,
		ST_LIST_LEN, ST_RCP_LEN, ST_RCP_DATA, ST_RCP_COMMA, ST_LIST_COMMA,
		ST_FAILED
	} parse_st_t;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_TYPED, ROW_RETUNE} row_mode_t;

	typedef enum int {
		BRK_BAD_DIGIT, BRK_HUGE_LEN, BRK_EMPTY_MSG, BRK_BAD_MODE,
		BRK_NO_COMMA, BRK_RCP_OVERRUN, BRK_LIST_SHORT
	} break_t;

	typedef struct packed {
		row_mode_t  mode;
		logic [7:0] b;
		logic [2:0] kind;
		logic [7:0] data;
		logic [1:0] verd;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [0:0]  cfg_index;
	logic [15:0] cfg_data;

	qpd_in_if  in_ch();
	qpd_out_if out_ch();

	qmtp_packet_deframer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	parse_st_t   ps;
	logic [31:0] len_acc;
	logic [31:0] list_left;
	logic        crlf_on;
	logic        cr_pending;
	logic        addr_drop;
	logic [1:0]  addr_verd;
	logic [15:0] lim_reg;
	logic [9:0]  sfx_reg;

	qpd_result_t awaited_items[$];
	qpd_result_t step_items[$];
	logic [7:0]  wire_bytes[$];
	stim_row_t   dir_rows[$];

	int unsigned mismatch_count;
	int unsigned result_count;
	int unsigned fed_bytes;
	int unsigned cycle_count;
	logic        calm;

	function automatic void note(input logic [7:0] d, input logic [2:0] k,
			input logic [1:0] v, input logic [1:0] c);
		qpd_result_t r;
		r.data_byte = d;
		r.item_kind = k;
		r.verdict = v;
		r.error_code = c;
		r.run_last = 1'b0;
		step_items.push_back(r);
	endfunction

	function automatic void latch_error(input logic [1:0] c);
		ps = ST_FAILED;
		note(8'h00, KIND_ERROR, VERD_OK, c);
	endfunction

	function automatic logic [1:0] take_len_digit(input logic [7:0] b);
		if (len_acc > 32'(LEN_CEILING)) return ERR_LEN;
		if (b < CH_ZERO || b > CH_NINE) return ERR_PROTO;
		len_acc = len_acc * 32'd10 + 32'(b - CH_ZERO);
		return ERR_NONE;
	endfunction

	function automatic void deframe_byte(input logic [7:0] b);
		logic [1:0]  e;
		logic [32:0] span;
		qpd_result_t r;
		step_items.delete();
		case (ps)
			ST_MSG_LEN, ST_SND_LEN, ST_LIST_LEN: begin
				if (b == CH_COLON) begin
					if (ps == ST_MSG_LEN) begin
						if (len_acc == 0) latch_error(ERR_PROTO);
						else ps = ST_MSG_MODE;
					end else if (ps == ST_SND_LEN) begin
						addr_drop = len_acc >= 32'(lim_reg);
						addr_verd = addr_drop ? VERD_LONG : VERD_OK;
						ps = (len_acc != 0) ? ST_SND_DATA : ST_SND_COMMA;
					end else begin
						list_left = len_acc;
						len_acc = 0;
						ps = (list_left != 0) ? ST_RCP_LEN : ST_LIST_COMMA;
					end
				end else begin
					e = take_len_digit(b);
					if (e != ERR_NONE) latch_error(e);
				end
			end
			ST_MSG_MODE: begin
				if (b == CH_LF || b == CH_CR) begin
					crlf_on = (b == CH_CR);
					cr_pending = 1'b0;
					len_acc = len_acc - 32'd1;
					ps = (len_acc != 0) ? ST_BODY : ST_MSG_COMMA;
				end else begin
					latch_error(ERR_PROTO);
				end
			end
			ST_BODY: begin
				len_acc = len_acc - 32'd1;
				if (!crlf_on) begin
					note(b, KIND_BODY, VERD_OK, ERR_NONE);
				end else if (cr_pending) begin
					if (b == CH_LF) begin
						note(CH_LF, KIND_BODY, VERD_OK, ERR_NONE);
						cr_pending = 1'b0;
					end else if (b == CH_CR && len_acc != 0) begin
						note(CH_CR, KIND_BODY, VERD_OK, ERR_NONE);
					end else begin
						note(CH_CR, KIND_BODY, VERD_OK, ERR_NONE);
						note(b, KIND_BODY, VERD_OK, ERR_NONE);
						cr_pending = 1'b0;
					end
				end else if (b == CH_CR && len_acc != 0) begin
					cr_pending = 1'b1;
				end else begin
					note(b, KIND_BODY, VERD_OK, ERR_NONE);
				end
				if (len_acc == 0) ps = ST_MSG_COMMA;
			end
			ST_SND_DATA, ST_RCP_DATA: begin
				if (!addr_drop) begin
					if (b == CH_NUL) addr_verd = VERD_NUL;
					note(b, (ps == ST_SND_DATA) ? KIND_SENDER : KIND_RECIPIENT, VERD_OK, ERR_NONE);
				end
				len_acc = len_acc - 32'd1;
				if (len_acc == 0) ps = (ps == ST_SND_DATA) ? ST_SND_COMMA : ST_RCP_COMMA;
			end
			ST_RCP_LEN: begin
				if (list_left == 0) begin
					latch_error(ERR_PROTO);
				end else begin
					list_left = list_left - 32'd1;
					if (b == CH_COLON) begin
						if (len_acc >= list_left) begin
							latch_error(ERR_PROTO);
						end else begin
							list_left = list_left - len_acc - 32'd1;
							span = {1'b0, len_acc};
							span = span + 33'(sfx_reg);
							addr_drop = span >= 33'(lim_reg);
							addr_verd = addr_drop ? VERD_LONG : VERD_OK;
							ps = (len_acc != 0) ? ST_RCP_DATA : ST_RCP_COMMA;
						end
					end else begin
						e = take_len_digit(b);
						if (e != ERR_NONE) latch_error(e);
					end
				end
			end
			ST_MSG_COMMA, ST_SND_COMMA, ST_RCP_COMMA, ST_LIST_COMMA: begin
				if (b != CH_COMMA) begin
					latch_error(ERR_PROTO);
				end else begin
					len_acc = 0;
					if (ps == ST_MSG_COMMA) begin
						note(8'h00, KIND_BODY_END, VERD_OK, ERR_NONE);
						ps = ST_SND_LEN;
					end else if (ps == ST_SND_COMMA) begin
						note(8'h00, KIND_SND_END, addr_verd, ERR_NONE);
						ps = ST_LIST_LEN;
					end else if (ps == ST_RCP_COMMA) begin
						note(8'h00, KIND_RCP_END, addr_verd, ERR_NONE);
						ps = (list_left != 0) ? ST_RCP_LEN : ST_LIST_COMMA;
					end else begin
						note(8'h00, KIND_PKT_END, VERD_OK, ERR_NONE);
						ps = ST_MSG_LEN;
						list_left = 0;
						crlf_on = 1'b0;
						cr_pending = 1'b0;
					end
					addr_drop = 1'b0;
					addr_verd = VERD_OK;
				end
			end
			default: ;
		endcase
		if (step_items.size() != 0) begin
			r = step_items.pop_back();
			r.run_last = 1'b1;
			step_items.push_back(r);
		end
	endfunction

	function automatic void stage(input logic [7:0] b, input row_mode_t m,
			input logic [2:0] k, input logic [7:0] d, input logic [1:0] v);
		stim_row_t row;
		row.mode = m;
		row.b = b;
		row.kind = k;
		row.data = d;
		row.verd = v;
		dir_rows.push_back(row);
	endfunction

	function automatic void put_str(input string s);
		int i;
		for (i = 0; i < s.len(); i++) wire_bytes.push_back(s[i]);
	endfunction

	function automatic string len_text(input int unsigned v);
		string s;
		s = $sformatf("%0d:", v);
		if ($urandom_range(0, 7) == 0) s = {"00", s};
		return s;
	endfunction

	function automatic void put_addr(input int unsigned n);
		int unsigned i;
		for (i = 0; i < n; i++)
			wire_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
	endfunction

	function automatic void build_packet();
		int unsigned blen, slen, nrcp, rlen, k, i, start;
		int          j;
		logic        cr_mode;
		logic [7:0]  b;
		string       s;
		cr_mode = 1'($urandom_range(0, 1));
		blen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		put_str(len_text(blen + 1));
		wire_bytes.push_back(cr_mode ? CH_CR : CH_LF);
		for (i = 0; i < blen; i++) begin
			k = $urandom_range(0, 5);
			if (cr_mode && k < 2) b = CH_CR;
			else if (cr_mode && k == 2) b = CH_LF;
			else b = 8'($urandom_range(0, 255));
			wire_bytes.push_back(b);
		end
		wire_bytes.push_back(CH_COMMA);
		slen = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 7);
		put_str(len_text(slen));
		put_addr(slen);
		wire_bytes.push_back(CH_COMMA);
		start = wire_bytes.size();
		nrcp = $urandom_range(0, 3);
		for (i = 0; i < nrcp; i++) begin
			rlen = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
			put_str(len_text(rlen));
			put_addr(rlen);
			wire_bytes.push_back(CH_COMMA);
		end
		s = len_text(wire_bytes.size() - start);
		for (j = s.len() - 1; j >= 0; j--) wire_bytes.insert(start, s[j]);
		wire_bytes.push_back(CH_COMMA);
	endfunction

	function automatic void build_break(input break_t k);
		logic [7:0] b;
		case (k)
			BRK_BAD_DIGIT: begin
				put_str("1");
				do b = 8'($urandom_range(0, 255));
				while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_COLON);
				wire_bytes.push_back(b);
			end
			BRK_HUGE_LEN: put_str("99999999999");
			BRK_EMPTY_MSG: put_str("0:");
			BRK_BAD_MODE: begin
				put_str("2:");
				do b = 8'($urandom_range(0, 255));
				while (b == CH_LF || b == CH_CR);
				wire_bytes.push_back(b);
			end
			BRK_NO_COMMA: begin
				put_str("1:");
				wire_bytes.push_back(CH_LF);
				do b = 8'($urandom_range(0, 255));
				while (b == CH_COMMA);
				wire_bytes.push_back(b);
			end
			BRK_RCP_OVERRUN: begin
				put_str("1:");
				wire_bytes.push_back(CH_LF);
				put_str(",0:,3:5:");
			end
			default: begin
				put_str("1:");
				wire_bytes.push_back(CH_LF);
				put_str(",0:,1:77");
			end
		endcase
	endfunction

	function automatic int unsigned draw_gap(input logic quiet);
		int unsigned r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic flag_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatch_count++;
		$display("result %0d: %s is %0d, expected %0d", result_count, what, got, want);
	endtask

	task automatic push_byte(input logic [7:0] b, input row_mode_t m, input qpd_result_t typed);
		int unsigned gap;
		gap = draw_gap(calm);
		@(negedge clk);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.in_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		deframe_byte(b);
		if (m == ROW_PREDICT) begin
			foreach (step_items[i]) awaited_items.push_back(step_items[i]);
		end else if (m == ROW_TYPED) begin
			awaited_items.push_back(typed);
		end
	endtask

	task automatic send_built();
		logic [7:0]  b;
		qpd_result_t unused;
		unused = '0;
		while (wire_bytes.size() != 0) begin
			b = wire_bytes.pop_front();
			push_byte(b, ROW_PREDICT, unused);
			fed_bytes++;
		end
	endtask

	task automatic settle();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (awaited_items.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_IDX_ADDR_LIMIT) lim_reg = val;
		else sfx_reg = val[9:0];
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int unsigned hold;
		hold = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold != 0) begin
				out_ch.ready <= 1'b0;
				hold--;
			end else begin
				hold = draw_gap(calm);
				out_ch.ready <= (hold == 0);
				if (hold != 0) hold--;
			end
		end
	end

	always @(posedge clk) begin
		qpd_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (awaited_items.size() == 0) begin
				flag_mismatch("item with nothing pending, item_kind", out_ch.item_kind, 0);
			end else begin
				want = awaited_items.pop_front();
				if (out_ch.data_byte !== want.data_byte)
					flag_mismatch("data_byte", out_ch.data_byte, want.data_byte);
				if (out_ch.item_kind !== want.item_kind)
					flag_mismatch("item_kind", out_ch.item_kind, want.item_kind);
				if (out_ch.verdict !== want.verdict)
					flag_mismatch("verdict", out_ch.verdict, want.verdict);
				if (out_ch.error_code !== want.error_code)
					flag_mismatch("error_code", out_ch.error_code, want.error_code);
				if (out_ch.run_last !== want.run_last)
					flag_mismatch("run_last", out_ch.run_last, want.run_last);
			end
			result_count++;
		end
	end

	initial begin
		stim_row_t   row;
		qpd_result_t typed;
		int unsigned p;
		logic [15:0] lim;
		logic [9:0]  sfx;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		cfg_we = 1'b0;
		cfg_index = CFG_IDX_ADDR_LIMIT;
		cfg_data = 16'h0000;
		arst_n = 1'b0;
		calm = 1'b0;
		mismatch_count = 0;
		result_count = 0;
		fed_bytes = 0;
		cycle_count = 0;
		ps = ST_MSG_LEN;
		len_acc = 0;
		list_left = 0;
		crlf_on = 1'b0;
		cr_pending = 1'b0;
		addr_drop = 1'b0;
		addr_verd = VERD_OK;
		lim_reg = ADDR_LIMIT_RESET;
		sfx_reg = RELAY_SUFFIX_RESET;

		// LF packet at reset settings: extreme body byte, NUL sender, one recipient
		stage("2", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(CH_LF, ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(8'hFF, ROW_TYPED, KIND_BODY, 8'hFF, VERD_OK);
		stage(",", ROW_TYPED, KIND_BODY_END, 8'h00, VERD_OK);
		stage("1", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(CH_NUL, ROW_TYPED, KIND_SENDER, 8'h00, VERD_OK);
		stage(",", ROW_TYPED, KIND_SND_END, 8'h00, VERD_NUL);
		stage("4", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage("1", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage("a", ROW_TYPED, KIND_RECIPIENT, "a", VERD_OK);
		stage(",", ROW_TYPED, KIND_RCP_END, 8'h00, VERD_OK);
		stage(",", ROW_TYPED, KIND_PKT_END, 8'h00, VERD_OK);
		stage(8'h00, ROW_RETUNE, KIND_BODY, 8'h00, VERD_OK);
		// CRLF packet: folded pair, lone CR mid body and at the end, long addresses
		stage("6", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(CH_CR, ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(CH_CR, ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(CH_LF, ROW_TYPED, KIND_BODY, CH_LF, VERD_OK);
		stage(CH_CR, ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage("y", ROW_PREDICT, KIND_BODY, 8'h00, VERD_OK);
		stage(CH_CR, ROW_TYPED, KIND_BODY, CH_CR, VERD_OK);
		stage(",", ROW_TYPED, KIND_BODY_END, 8'h00, VERD_OK);
		stage("2", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage("a", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage("b", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(",", ROW_TYPED, KIND_SND_END, 8'h00, VERD_LONG);
		stage("4", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage("1", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(":", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage("c", ROW_SILENT, KIND_BODY, 8'h00, VERD_OK);
		stage(",", ROW_TYPED, KIND_RCP_END, 8'h00, VERD_LONG);
		stage(",", ROW_TYPED, KIND_PKT_END, 8'h00, VERD_OK);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.mode == ROW_RETUNE) begin
				settle();
				write_reg(CFG_IDX_ADDR_LIMIT, DIR_LIMIT);
				write_reg(CFG_IDX_RELAY_SUFFIX, {6'd0, DIR_SUFFIX});
			end else begin
				typed.data_byte = row.data;
				typed.item_kind = row.kind;
				typed.verdict = row.verd;
				typed.error_code = ERR_NONE;
				typed.run_last = 1'b1;
				push_byte(row.b, row.mode, typed);
			end
		end

		for (p = 0; p < PHASES; p++) begin
			settle();
			case (p)
				0: begin lim = 16'd1; sfx = 10'd0; end
				1: begin lim = 16'd65535; sfx = 10'd999; end
				2: begin lim = 16'd3; sfx = 10'd1; end
				3: begin lim = 16'd6; sfx = 10'd2; end
				4: begin lim = 16'd2; sfx = 10'd999; end
				5: begin lim = 16'd1000; sfx = 10'd0; end
				6: begin
					lim = 16'($urandom_range(1, 12));
					sfx = 10'($urandom_range(0, 4));
				end
				default: begin lim = 16'd65535; sfx = 10'd0; end
			endcase
			write_reg(CFG_IDX_ADDR_LIMIT, lim);
			write_reg(CFG_IDX_RELAY_SUFFIX, {6'd0, sfx});
			calm = (p == 2 || p == 5);
			while (fed_bytes < (p + 1) * RANDOM_BYTES / PHASES) begin
				build_packet();
				send_built();
			end
		end

		// latch one error at the very end, then feed bytes that must be dropped
		settle();
		calm = 1'b0;
		build_break(break_t'($urandom_range(0, 6)));
		repeat (16) wire_bytes.push_back(8'($urandom_range(0, 255)));
		send_built();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (awaited_items.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
